/* hdl/mivm_pkg.sv */
// ----------------------------------------------------------------------------
// mivm_pkg
// Shared widths, register indexes and item types of the message interval
// window monitor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mivm_pkg;

  // Width of a millisecond timestamp (range 32 to 64).
  localparam int unsigned TIME_BITS = 48;
  localparam int unsigned END_BITS  = TIME_BITS + 1;
  localparam int unsigned CNT_W     = 32;
  localparam int unsigned SRC_W     = 16;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned CFG_IDX_W = 4;

  // A window end can only overflow the time range at the widest timestamp.
  localparam bit SAT_END = (TIME_BITS >= 64);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = CFG_IDX_W'(1);

  typedef struct packed {
    logic [TIME_BITS-1:0] timestamp_ms;
    logic [SRC_W-1:0]     source_id;
  } mivm_in_t;

  typedef struct packed {
    logic                 window_closed;
    logic [TIME_BITS-1:0] closed_start_ms;
    logic [END_BITS-1:0]  closed_end_ms;
    logic [CNT_W-1:0]     closed_violations;
    logic [CNT_W-1:0]     closed_messages;
    logic [SRC_W-1:0]     closed_source_id;
    logic                 closed_id_mismatch;
    logic [TIME_BITS-1:0] last_gap_ms;
    logic [CNT_W-1:0]     violation_total;
    logic [CNT_W-1:0]     windows_total;
    logic [CNT_W-1:0]     regression_total;
    logic                 window_active;
  } mivm_out_t;

  // Configuration seen by the step logic.
  typedef struct packed {
    logic [CFG_W-1:0] threshold_ms;
    logic [CFG_W-1:0] window_ms;
  } mivm_cfg_t;

endpackage

`default_nettype wire

/* hdl/mivm_in_stage.sv */
// ----------------------------------------------------------------------------
// mivm_in_stage
// Input register: holds one accepted item until the step logic takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mivm_in_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire mivm_pkg::mivm_in_t in_item_i,
  input  wire logic              advance_i,
  output logic                   stage_valid_o,
  output mivm_pkg::mivm_in_t      stage_item_o
);
  import mivm_pkg::*;

  logic     valid_q, valid_d;
  mivm_in_t item_q;

  // Take a new item whenever the held one leaves or none is held.
  assign in_ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

  assign stage_valid_o = valid_q;
  assign stage_item_o  = item_q;

endmodule

`default_nettype wire

/* hdl/mivm_step.sv */
// ----------------------------------------------------------------------------
// mivm_step
// Monitor state and the combinational step: gap, violation, window update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mivm_step (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               fire_i,
  input  wire mivm_pkg::mivm_in_t  item_i,
  input  wire mivm_pkg::mivm_cfg_t cfg_i,
  output mivm_pkg::mivm_out_t      result_o
);
  import mivm_pkg::*;

  logic [TIME_BITS-1:0] prev_time_q, prev_time_d;
  logic                 win_open_q, win_open_d;
  logic [TIME_BITS-1:0] win_start_q, win_start_d;
  logic [END_BITS-1:0]  win_end_q, win_end_d;
  logic [CNT_W-1:0]     win_viol_q, win_viol_d;
  logic [CNT_W-1:0]     win_msg_q, win_msg_d;
  logic [SRC_W-1:0]     win_src_q, win_src_d;
  logic                 win_mism_q, win_mism_d;
  logic [CNT_W-1:0]     cnt_viol_q, cnt_viol_d;
  logic [CNT_W-1:0]     cnt_win_q, cnt_win_d;
  logic [CNT_W-1:0]     cnt_regr_q, cnt_regr_d;

  logic [TIME_BITS-1:0] t;
  logic                 have_prev, backwards, checked, viol, close, open_kept;
  logic [TIME_BITS-1:0] gap;
  logic [END_BITS-1:0]  end_sum;

  always_comb begin
    t         = item_i.timestamp_ms;
    have_prev = (prev_time_q != '0);
    backwards = have_prev && (t < prev_time_q);
    checked   = have_prev && !backwards;
    gap       = checked ? (t - prev_time_q) : '0;
    viol      = checked && (gap > TIME_BITS'(cfg_i.threshold_ms));
    close     = win_open_q && ({1'b0, t} >= win_end_q);
    open_kept = win_open_q && !close;

    end_sum = {1'b0, t} + END_BITS'(cfg_i.window_ms);
    if (SAT_END && end_sum[TIME_BITS]) begin
      end_sum = {1'b0, {TIME_BITS{1'b1}}};
    end

    prev_time_d = t;
    win_open_d  = open_kept;
    win_start_d = win_start_q;
    win_end_d   = win_end_q;
    win_viol_d  = win_viol_q;
    win_msg_d   = win_msg_q;
    win_src_d   = win_src_q;
    win_mism_d  = win_mism_q;
    cnt_viol_d  = cnt_viol_q + CNT_W'(viol);
    cnt_win_d   = cnt_win_q + CNT_W'(close);
    cnt_regr_d  = cnt_regr_q + CNT_W'(backwards);

    if (viol && !open_kept) begin
      // Open a fresh window on this item.
      win_open_d  = 1'b1;
      win_start_d = t;
      win_end_d   = end_sum;
      win_viol_d  = CNT_W'(1);
      win_msg_d   = CNT_W'(1);
      win_src_d   = item_i.source_id;
      win_mism_d  = 1'b0;
    end else if (open_kept) begin
      win_msg_d = win_msg_q + CNT_W'(1);
      if (viol) begin
        win_viol_d = win_viol_q + CNT_W'(1);
        if (item_i.source_id != win_src_q) begin
          win_mism_d = 1'b1;
        end
      end
    end

    result_o.window_closed      = close;
    result_o.closed_start_ms    = close ? win_start_q : '0;
    result_o.closed_end_ms      = close ? win_end_q : '0;
    result_o.closed_violations  = close ? win_viol_q : '0;
    result_o.closed_messages    = close ? win_msg_q : '0;
    result_o.closed_source_id   = close ? win_src_q : '0;
    result_o.closed_id_mismatch = close && win_mism_q;
    result_o.last_gap_ms        = gap;
    result_o.violation_total    = cnt_viol_d;
    result_o.windows_total      = cnt_win_d;
    result_o.regression_total   = cnt_regr_d;
    result_o.window_active      = win_open_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_time_q <= '0;
      win_open_q  <= 1'b0;
      win_start_q <= '0;
      win_end_q   <= '0;
      win_viol_q  <= '0;
      win_msg_q   <= '0;
      win_src_q   <= '0;
      win_mism_q  <= 1'b0;
      cnt_viol_q  <= '0;
      cnt_win_q   <= '0;
      cnt_regr_q  <= '0;
    end else if (fire_i) begin
      prev_time_q <= prev_time_d;
      win_open_q  <= win_open_d;
      win_start_q <= win_start_d;
      win_end_q   <= win_end_d;
      win_viol_q  <= win_viol_d;
      win_msg_q   <= win_msg_d;
      win_src_q   <= win_src_d;
      win_mism_q  <= win_mism_d;
      cnt_viol_q  <= cnt_viol_d;
      cnt_win_q   <= cnt_win_d;
      cnt_regr_q  <= cnt_regr_d;
    end
  end

endmodule

`default_nettype wire

/* hdl/mivm_out_reg.sv */
// ----------------------------------------------------------------------------
// mivm_out_reg
// Result register: holds one result item until the consumer takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mivm_out_reg (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               load_i,
  input  wire mivm_pkg::mivm_out_t result_i,
  output logic                    advance_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output mivm_pkg::mivm_out_t      out_item_o
);
  import mivm_pkg::*;

  logic      valid_q, valid_d;
  mivm_out_t item_q;

  // Room for a new result when empty or the held one leaves this cycle.
  assign advance_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (advance_o) begin
      valid_d = load_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && load_i) begin
      item_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

`default_nettype wire

/* hdl/message_interval_window_monitor_core.sv */
// ----------------------------------------------------------------------------
// message_interval_window_monitor_core
// Checks the gap between message arrivals against a threshold and gathers
// violations into timed windows, reporting each window when it closes.
// ----------------------------------------------------------------------------
// Flow: an accepted item waits in the input register and its result is loaded
//   into the result register once it has room; a held result stalls the input.
// Throughput: one item per cycle while the result register is not held; the
//   step logic settles the whole update combinationally between the registers.
// Reset: rst_ni low clears all state, counters and the valid flags of both
//   registers at once; the block is ready for items as soon as reset is
//   released.
`timescale 1ns / 1ps
`default_nettype none

module message_interval_window_monitor_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire mivm_pkg::mivm_in_t              in_item_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output mivm_pkg::mivm_out_t                  out_item_o,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [mivm_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [mivm_pkg::CFG_W-1:0]     cfg_data_i
);
  import mivm_pkg::*;

  logic      stage_valid;
  mivm_in_t  stage_item;
  logic      advance;
  logic      fire;
  mivm_out_t result;
  mivm_cfg_t cfg_q, cfg_d;

  // Configuration: always ready; the sender must write only while no item
  // is in flight, so none sees a register change half-way (not enforced).
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_THRESHOLD: cfg_d.threshold_ms = cfg_data_i;
        REG_WINDOW:    cfg_d.window_ms    = cfg_data_i;
        default:       cfg_d = cfg_q;   // drop writes beyond the register list
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Hold the accepted item in the input register.
  mivm_in_stage u_in_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_item_i     (in_item_i),
    .advance_i     (advance),
    .stage_valid_o (stage_valid),
    .stage_item_o  (stage_item)
  );

  // Advance the state only when the result has a place to go.
  assign fire = stage_valid && advance;

  mivm_step u_step (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (stage_item),
    .cfg_i    (cfg_q),
    .result_o (result)
  );

  mivm_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (stage_valid),
    .result_i    (result),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  // A result only appears after an item was held in the input register.
  a_out_from_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(stage_valid))
    else $error("result valid without a held item");

  // Back-pressure on the input only while both registers are full.
  a_ready_low_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (stage_valid && out_valid_o && !out_ready_i))
    else $error("input stalled with room in the pipeline");

  // Closed-window fields stay zero when nothing closed.
  a_closed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_item_o.window_closed) |->
      (out_item_o.closed_messages == '0 && out_item_o.closed_end_ms == '0 &&
       !out_item_o.closed_id_mismatch))
    else $error("closed-window fields set without a close");

  // An item stepped through the logic lands in the result register.
  a_fire_holds_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_o)
    else $error("fired item did not reach the result register");

endmodule

`default_nettype wire
